### rtl/core/lome_pkg.sv
// lome_pkg: shared widths, op codes, command/slot/trade structs and engine states
// for the order matching engine; no dependencies
`timescale 1ns / 1ps
package lome_pkg;
   localparam int BOOK_SLOTS   = 64;
   localparam int KEY_BITS     = 32;
   localparam int PRICE_BITS   = 16;
   localparam int QTY_BITS     = 24;
   localparam int ARRIVAL_BITS = 32;
   localparam int SLOT_W       = $clog2(BOOK_SLOTS);
   localparam int CNT_W        = $clog2(BOOK_SLOTS + 1);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef logic [1:0] op_type;
   localparam op_type OP_NEW    = 2'd0;
   localparam op_type OP_CANCEL = 2'd1;
   localparam op_type OP_MODIFY = 2'd2;

   typedef struct packed {
      op_type                op;
      logic [KEY_BITS-1:0]   key;
      logic                  sell;
      logic                  rest;
      logic [PRICE_BITS-1:0] price;
      logic [QTY_BITS-1:0]   qty;
   } cmd_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]     key;
      logic                    sell;
      logic [PRICE_BITS-1:0]   price;
      logic [QTY_BITS-1:0]     remaining;
      logic [ARRIVAL_BITS-1:0] arrival;
   } slot_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   resting_key;
      logic [PRICE_BITS-1:0] resting_price;
      logic [QTY_BITS-1:0]   fill_quantity;
      logic [KEY_BITS-1:0]   incoming_key;
      logic [PRICE_BITS-1:0] incoming_price;
      logic                  last;
   } trade_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FIND, ST_MSCAN, ST_FILL, ST_END, ST_RSCAN
   } state_type;
endpackage

### rtl/core/lome_if.sv
// lome_if: valid/ready channel interfaces for order items and trade items
// depends on lome_pkg
`timescale 1ns / 1ps
interface lome_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     op;
   logic [lome_pkg::KEY_BITS-1:0]   order_id;
   logic                           side_sell;
   logic                           immediate_or_cancel;
   logic [lome_pkg::PRICE_BITS-1:0] limit_price;
   logic [lome_pkg::QTY_BITS-1:0]   order_quantity;
   modport source (output valid, op, order_id, side_sell, immediate_or_cancel,
                   limit_price, order_quantity, input ready);
   modport sink (input valid, op, order_id, side_sell, immediate_or_cancel,
                 limit_price, order_quantity, output ready);
endinterface

interface lome_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lome_pkg::KEY_BITS-1:0]   resting_key;
   logic [lome_pkg::PRICE_BITS-1:0] resting_price;
   logic [lome_pkg::QTY_BITS-1:0]   fill_quantity;
   logic [lome_pkg::KEY_BITS-1:0]   incoming_key;
   logic [lome_pkg::PRICE_BITS-1:0] incoming_price;
   logic                           last;
   modport source (output valid, resting_key, resting_price, fill_quantity,
                   incoming_key, incoming_price, last, input ready);
   modport sink (input valid, resting_key, resting_price, fill_quantity,
                 incoming_key, incoming_price, last, output ready);
endinterface

### rtl/core/lome_front.sv
// lome_front: accepts order items, drops ones that do nothing, registers a command
// depends on lome_pkg, lome_if
`timescale 1ns / 1ps
module lome_front (
   input  logic              clock,
   input  logic              reset,
   lome_req_if.sink          req,
   output logic              cmd_vld,
   input  logic              cmd_rdy,
   output lome_pkg::cmd_type cmd
);
   logic              vld_ff, vld_in;
   lome_pkg::cmd_type cmd_ff, cmd_in;
   logic              take, keep, priced;

   assign req.ready = !vld_ff || cmd_rdy;
   assign take      = req.valid && req.ready;
   assign priced    = (req.limit_price != '0) && (req.order_quantity != '0);
   // cancel ignores price and quantity; unknown ops fall out here
   assign keep = (req.op == lome_pkg::OP_CANCEL) ||
                 (((req.op == lome_pkg::OP_NEW) || (req.op == lome_pkg::OP_MODIFY)) && priced);

   always_comb begin
      vld_in = vld_ff;
      cmd_in = cmd_ff;
      if (take) begin
         vld_in       = keep;
         cmd_in.op    = req.op;
         cmd_in.key   = req.order_id;
         cmd_in.sell  = req.side_sell;
         cmd_in.rest  = (req.op == lome_pkg::OP_MODIFY) || !req.immediate_or_cancel;
         cmd_in.price = req.limit_price;
         cmd_in.qty   = req.order_quantity;
      end else if (cmd_rdy) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_vld = vld_ff;
   assign cmd     = cmd_ff;
endmodule

### rtl/core/lome_queue.sv
// lome_queue: short command queue between front and matching back end
// depends on lome_pkg
`timescale 1ns / 1ps
module lome_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_vld,
   output logic              push_rdy,
   input  lome_pkg::cmd_type push_cmd,
   output logic              pop_vld,
   input  logic              pop_rdy,
   output lome_pkg::cmd_type pop_cmd
);
   lome_pkg::cmd_type                 entry_ff [lome_pkg::QUEUE_DEPTH];
   logic [lome_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [lome_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_push, do_pop;

   assign push_rdy = count_ff != lome_pkg::QCNT_W'(lome_pkg::QUEUE_DEPTH);
   assign pop_vld  = count_ff != '0;
   assign do_push  = push_vld && push_rdy;
   assign do_pop   = pop_vld && pop_rdy;
   assign pop_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == lome_pkg::QPTR_W'(lome_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == lome_pkg::QPTR_W'(lome_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule

### rtl/core/lome_back.sv
// lome_back: book memory, slot scans, fills and the trade output register
// depends on lome_pkg, lome_if
`timescale 1ns / 1ps
module lome_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_vld,
   output logic              cmd_rdy,
   input  lome_pkg::cmd_type cmd,
   lome_rsp_if.source        rsp
);
   localparam int SW = lome_pkg::SLOT_W;
   localparam int CW = lome_pkg::CNT_W;

   lome_pkg::state_type state_ff, state_in;
   lome_pkg::cmd_type   cmd_ff, cmd_in;
   logic [lome_pkg::QTY_BITS-1:0]     qty_ff, qty_in;
   logic [CW-1:0]                     n_ff, n_in, rd_idx_ff, rd_idx_in;
   logic                              cand_vld_ff, cand_vld_in;
   logic [SW-1:0]                     cand_idx_ff, cand_idx_in;
   lome_pkg::slot_type                rd_data_ff;
   logic                              hit_ff, hit_in, free_hit_ff, free_hit_in;
   logic [SW-1:0]                     hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   lome_pkg::slot_type                best_ff, best_in;
   logic [lome_pkg::ARRIVAL_BITS-1:0] best_age_ff, best_age_in, arrival_ff, arrival_in;
   logic                              pend_vld_ff, pend_vld_in;
   lome_pkg::trade_type               pend_ff, pend_in;
   logic                              rsp_vld_ff, rsp_vld_in;
   lome_pkg::trade_type               rsp_ff, rsp_in;
   logic                              valid_ff [lome_pkg::BOOK_SLOTS];

   lome_pkg::slot_type                mem [lome_pkg::BOOK_SLOTS];
   logic                              mem_we, mem_re;
   logic [SW-1:0]                     mem_waddr, mem_raddr;
   lome_pkg::slot_type                mem_wdata;

   logic                              clr_en, set_en;
   logic [SW-1:0]                     clr_idx, set_idx;
   logic                              push_en;
   lome_pkg::trade_type               push_data;

   logic                              out_free, scan_done, cand_live, key_eq, crosses, better;
   logic [lome_pkg::ARRIVAL_BITS-1:0] cand_age;
   logic [lome_pkg::QTY_BITS-1:0]     fill_qty, qty_left, rem_left;
   logic                              fill_go, end_go, match_over;

   assign out_free  = !rsp_vld_ff || rsp.ready;
   assign scan_done = (rd_idx_ff == CW'(lome_pkg::BOOK_SLOTS)) && !cand_vld_ff;
   assign cand_live = cand_vld_ff && valid_ff[cand_idx_ff];
   assign key_eq    = rd_data_ff.key == cmd_ff.key;
   assign cand_age  = arrival_ff - rd_data_ff.arrival;
   assign crosses   = cand_live && (rd_data_ff.sell != cmd_ff.sell) &&
                      (cmd_ff.sell ? (rd_data_ff.price >= cmd_ff.price)
                                   : (rd_data_ff.price <= cmd_ff.price));
   // best price first, then oldest, then lowest slot (earlier in the scan)
   assign better    = !hit_ff ||
                      (cmd_ff.sell ? (rd_data_ff.price > best_ff.price)
                                   : (rd_data_ff.price < best_ff.price)) ||
                      ((rd_data_ff.price == best_ff.price) && (cand_age > best_age_ff));
   assign fill_qty  = (best_ff.remaining < qty_ff) ? best_ff.remaining : qty_ff;
   assign qty_left  = qty_ff - fill_qty;
   assign rem_left  = best_ff.remaining - fill_qty;
   assign fill_go   = !pend_vld_ff || out_free;
   assign end_go    = !pend_vld_ff || out_free;
   assign match_over = (qty_left == '0) || (n_ff == CW'(lome_pkg::BOOK_SLOTS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lome_pkg::ST_IDLE: begin
            if (cmd_vld) begin
               state_in = (cmd.op == lome_pkg::OP_NEW) ? lome_pkg::ST_MSCAN
                                                       : lome_pkg::ST_FIND;
            end
         end
         lome_pkg::ST_FIND: begin
            if (scan_done) begin
               state_in = (hit_ff && (cmd_ff.op == lome_pkg::OP_MODIFY)) ?
                          lome_pkg::ST_MSCAN : lome_pkg::ST_IDLE;
            end
         end
         lome_pkg::ST_MSCAN: begin
            if (scan_done) begin
               state_in = hit_ff ? lome_pkg::ST_FILL : lome_pkg::ST_END;
            end
         end
         lome_pkg::ST_FILL: begin
            if (fill_go) begin
               state_in = match_over ? lome_pkg::ST_END : lome_pkg::ST_MSCAN;
            end
         end
         lome_pkg::ST_END: begin
            if (end_go) begin
               state_in = ((qty_ff != '0) && cmd_ff.rest) ? lome_pkg::ST_RSCAN
                                                          : lome_pkg::ST_IDLE;
            end
         end
         lome_pkg::ST_RSCAN: begin
            if (scan_done) begin
               state_in = lome_pkg::ST_IDLE;
            end
         end
         default: state_in = lome_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in      = cmd_ff;
      qty_in      = qty_ff;
      n_in        = n_ff;
      rd_idx_in   = rd_idx_ff;
      cand_vld_in = 1'b0;
      cand_idx_in = cand_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_hit_in = free_hit_ff;
      free_idx_in = free_idx_ff;
      best_in     = best_ff;
      best_age_in = best_age_ff;
      arrival_in  = arrival_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      cmd_rdy     = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_waddr   = hit_idx_ff;
      mem_raddr   = rd_idx_ff[SW-1:0];
      mem_wdata   = best_ff;
      clr_en      = 1'b0;
      clr_idx     = hit_idx_ff;
      set_en      = 1'b0;
      set_idx     = free_idx_ff;
      push_en     = 1'b0;
      push_data   = pend_ff;

      // shared slot sweep: one read issued per cycle, data checked in the next cycle
      if ((state_ff == lome_pkg::ST_FIND) || (state_ff == lome_pkg::ST_MSCAN) ||
          (state_ff == lome_pkg::ST_RSCAN)) begin
         if (rd_idx_ff != CW'(lome_pkg::BOOK_SLOTS)) begin
            mem_re      = 1'b1;
            rd_idx_in   = rd_idx_ff + 1'b1;
            cand_vld_in = 1'b1;
            cand_idx_in = rd_idx_ff[SW-1:0];
         end
      end

      unique case (state_ff)
         lome_pkg::ST_IDLE: begin
            cmd_rdy = 1'b1;
            if (cmd_vld) begin
               cmd_in      = cmd;
               qty_in      = cmd.qty;
               n_in        = '0;
               pend_vld_in = 1'b0;
               rd_idx_in   = '0;
               hit_in      = 1'b0;
               free_hit_in = 1'b0;
            end
         end
         lome_pkg::ST_FIND: begin
            if (cand_live && key_eq && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = cand_idx_ff;
            end
            if (scan_done) begin
               clr_en    = hit_ff;
               rd_idx_in = '0;
               hit_in    = 1'b0;
            end
         end
         lome_pkg::ST_MSCAN: begin
            if (crosses && better) begin
               hit_in      = 1'b1;
               hit_idx_in  = cand_idx_ff;
               best_in     = rd_data_ff;
               best_age_in = cand_age;
            end
         end
         lome_pkg::ST_FILL: begin
            if (fill_go) begin
               push_en                      = pend_vld_ff;
               push_data.last               = 1'b0;
               pend_vld_in                  = 1'b1;
               pend_in.resting_key          = best_ff.key;
               pend_in.resting_price        = best_ff.price;
               pend_in.fill_quantity        = fill_qty;
               pend_in.incoming_key         = cmd_ff.key;
               pend_in.incoming_price       = cmd_ff.price;
               pend_in.last                 = 1'b0;
               qty_in                       = qty_left;
               n_in                         = n_ff + 1'b1;
               mem_we                       = 1'b1;
               mem_wdata.remaining          = rem_left;
               clr_en                       = rem_left == '0;
               rd_idx_in                    = '0;
               hit_in                       = 1'b0;
            end
         end
         lome_pkg::ST_END: begin
            if (end_go) begin
               push_en        = pend_vld_ff;
               push_data.last = 1'b1;
               pend_vld_in    = 1'b0;
               rd_idx_in      = '0;
               hit_in         = 1'b0;
               free_hit_in    = 1'b0;
            end
         end
         lome_pkg::ST_RSCAN: begin
            if (cand_live && key_eq) begin
               hit_in = 1'b1;
            end
            if (cand_vld_ff && !valid_ff[cand_idx_ff] && !free_hit_ff) begin
               free_hit_in = 1'b1;
               free_idx_in = cand_idx_ff;
            end
            if (scan_done && !hit_ff && free_hit_ff) begin
               mem_we              = 1'b1;
               mem_waddr           = free_idx_ff;
               mem_wdata.key       = cmd_ff.key;
               mem_wdata.sell      = cmd_ff.sell;
               mem_wdata.price     = cmd_ff.price;
               mem_wdata.remaining = qty_ff;
               mem_wdata.arrival   = arrival_ff;
               set_en              = 1'b1;
               arrival_in          = arrival_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase

      rsp_vld_in = push_en ? 1'b1 : (rsp.ready ? 1'b0 : rsp_vld_ff);
      rsp_in     = push_en ? push_data : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lome_pkg::ST_IDLE;
         cand_vld_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         arrival_ff  <= '0;
         rd_idx_ff   <= '0;
         n_ff        <= '0;
         hit_ff      <= 1'b0;
         free_hit_ff <= 1'b0;
         for (int i = 0; i < lome_pkg::BOOK_SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff    <= state_in;
         cand_vld_ff <= cand_vld_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         arrival_ff  <= arrival_in;
         rd_idx_ff   <= rd_idx_in;
         n_ff        <= n_in;
         hit_ff      <= hit_in;
         free_hit_ff <= free_hit_in;
         if (clr_en) begin
            valid_ff[clr_idx] <= 1'b0;
         end
         if (set_en) begin
            valid_ff[set_idx] <= 1'b1;
         end
      end
      cmd_ff      <= cmd_in;
      qty_ff      <= qty_in;
      cand_idx_ff <= cand_idx_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      best_ff     <= best_in;
      best_age_ff <= best_age_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp.valid          = rsp_vld_ff;
   assign rsp.resting_key    = rsp_ff.resting_key;
   assign rsp.resting_price  = rsp_ff.resting_price;
   assign rsp.fill_quantity  = rsp_ff.fill_quantity;
   assign rsp.incoming_key   = rsp_ff.incoming_key;
   assign rsp.incoming_price = rsp_ff.incoming_price;
   assign rsp.last           = rsp_ff.last;
endmodule

### rtl/core/limit_order_matching_engine.sv
// limit_order_matching_engine: top level, front end, command queue and matching back end
// depends on lome_pkg, lome_if, lome_front, lome_queue, lome_back
//
//   channel    dir  handshake      carries
//   req_chan   in   valid/ready    op, order_id, side, ioc, limit_price, order_quantity
//   rsp_chan   out  valid/ready    one trade per fill, last on the final one
//
// every slot sweep reads the book memory one slot a cycle
// cancel: an accept step and one sweep; new: an accept step, one sweep and one fill
// step per trade, a closing sweep unless the order is used up or hits BOOK_SLOTS fills,
// a closing step, plus one more sweep when a remainder rests; modify adds one id sweep
// reset (synchronous) empties the book at once through per-slot valid flops
// the front keeps taking items while the back end works, until the queue fills;
// a fill waits only while an earlier trade sits unclaimed in the output register
`timescale 1ns / 1ps
module limit_order_matching_engine (
   input logic         clock,
   input logic         reset,
   lome_req_if.sink    req_chan,
   lome_rsp_if.source  rsp_chan
);
   logic              fq_vld, fq_rdy, qb_vld, qb_rdy;
   lome_pkg::cmd_type fq_cmd, qb_cmd;

   lome_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .cmd_vld (fq_vld),
      .cmd_rdy (fq_rdy),
      .cmd     (fq_cmd)
   );

   lome_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_vld (fq_vld),
      .push_rdy (fq_rdy),
      .push_cmd (fq_cmd),
      .pop_vld  (qb_vld),
      .pop_rdy  (qb_rdy),
      .pop_cmd  (qb_cmd)
   );

   lome_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cmd_vld (qb_vld),
      .cmd_rdy (qb_rdy),
      .cmd     (qb_cmd),
      .rsp     (rsp_chan)
   );

   // items that would do nothing never reach the queue
   a_front_drops_empty: assert property (@(posedge clock) disable iff (reset)
      fq_vld && (fq_cmd.op != lome_pkg::OP_CANCEL) |->
         (fq_cmd.price != '0) && (fq_cmd.qty != '0))
      else $error("priced command with zero price or quantity queued");

   a_fill_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.fill_quantity != '0)
      else $error("trade with zero fill quantity");

   a_prices_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.resting_price != '0) && (rsp_chan.incoming_price != '0))
      else $error("trade with zero price");
endmodule
